### rtl/core/hsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hotstring suffix matcher package
// Field widths, command codes, sequencer states and the word character test
// that the matcher and its beat interfaces share.
// ----------------------------------------------------------------------------
package hsm_pkg;

  localparam int ModeW     = 3;
  localparam int CharW     = 16;
  localparam int SelW      = 4;
  localparam int PosW      = 4;
  localparam int LenInW    = 5;
  localparam int EntryOutW = 4;
  localparam int DelW      = 4;
  localparam int FillW     = 8;

  localparam logic [CharW-1:0] CharSpace      = 16'h0020;
  localparam logic [CharW-1:0] CharUnderscore = 16'h005F;

  typedef enum logic [ModeW-1:0] {
    MODE_TYPE      = 3'd0,
    MODE_BKSP      = 3'd1,
    MODE_BREAK     = 3'd2,
    MODE_LOAD_CHAR = 3'd3,
    MODE_LOAD_LEN  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_BND,
    ST_CMP,
    ST_DONE
  } state_e;

  function automatic logic is_word_char(input logic [CharW-1:0] c);
    logic res;
    res = ((c >= 16'h0030) && (c <= 16'h0039)) ||
          ((c >= 16'h0041) && (c <= 16'h005A)) ||
          ((c >= 16'h0061) && (c <= 16'h007A)) ||
          (c == CharUnderscore);
    return res;
  endfunction

endpackage

### rtl/core/hsm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hotstring suffix matcher command channel
// Valid/ready channel carrying one command beat: a keystroke, an edit of the
// window or a load of the abbreviation table.
// ----------------------------------------------------------------------------
interface hsm_in_if
  import hsm_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [CharW-1:0]  char_code;
  logic [SelW-1:0]   entry_sel;
  logic [PosW-1:0]   char_pos;
  logic [LenInW-1:0] entry_len;

  modport source (
    output valid, mode, char_code, entry_sel, char_pos, entry_len,
    input  ready
  );

  modport sink (
    input  valid, mode, char_code, entry_sel, char_pos, entry_len,
    output ready
  );
endinterface

### rtl/core/hsm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hotstring suffix matcher result channel
// Valid/ready channel carrying one result beat for every command beat.
// ----------------------------------------------------------------------------
interface hsm_out_if
  import hsm_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 matched;
  logic [EntryOutW-1:0] match_entry;
  logic [DelW-1:0]      delete_count;
  logic [FillW-1:0]     window_fill;

  modport source (
    output valid, matched, match_entry, delete_count, window_fill,
    input  ready
  );

  modport sink (
    input  valid, matched, match_entry, delete_count, window_fill,
    output ready
  );
endinterface

### rtl/core/hsm_abbrev_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hotstring suffix matcher abbreviation store
// Character memory and length memory of the abbreviation table, with one
// valid bit per entry so that an entry never loaded reads as length zero.
// ----------------------------------------------------------------------------
module hsm_abbrev_store
  import hsm_pkg::*;
#(
  parameter int  NUM_ENTRIES = 16,
  parameter int  MAX_ABBREV  = 16,
  localparam int EW          = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
  localparam int IW          = (MAX_ABBREV > 1) ? $clog2(MAX_ABBREV) : 1,
  localparam int LW          = $clog2(MAX_ABBREV + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     char_we_i,
  input  logic                     len_we_i,
  input  logic [EW-1:0]            wr_entry_i,
  input  logic [IW-1:0]            wr_pos_i,
  input  logic [CharW-1:0]         wr_char_i,
  input  logic [LW-1:0]            wr_len_i,
  input  logic [EW-1:0]            rd_entry_i,
  input  logic [IW-1:0]            rd_pos_i,
  output logic [CharW-1:0]         rd_char_o,
  output logic [LW-1:0]            rd_len_o
);

  localparam int Depth = NUM_ENTRIES * MAX_ABBREV;
  localparam int PAW   = (Depth > 1) ? $clog2(Depth) : 1;

  logic [CharW-1:0]       char_mem [Depth];
  logic [LW-1:0]          len_mem  [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] vld_q;
  logic [CharW-1:0]       rd_char_q;
  logic [LW-1:0]          rd_len_q;
  logic                   rd_vld_q;
  logic [PAW-1:0]         wr_addr;
  logic [PAW-1:0]         rd_addr;

  assign wr_addr = PAW'(32'(wr_entry_i) * MAX_ABBREV + 32'(wr_pos_i));
  assign rd_addr = PAW'(32'(rd_entry_i) * MAX_ABBREV + 32'(rd_pos_i));

  always_ff @(posedge clk_i) begin
    if (char_we_i) begin
      char_mem[wr_addr] <= wr_char_i;
    end
    rd_char_q <= char_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (len_we_i) begin
      len_mem[wr_entry_i] <= wr_len_i;
    end
    rd_len_q <= len_mem[rd_entry_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (len_we_i) begin
        vld_q[wr_entry_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_entry_i];
    end
  end

  assign rd_char_o = rd_char_q;
  assign rd_len_o  = rd_vld_q ? rd_len_q : '0;

endmodule

### rtl/core/hotstring_suffix_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hotstring suffix matcher
// Keeps a window of typed characters and checks the abbreviation table, entry
// by entry and character by character, against the tail of the window.
//
//   Channel  Dir  Beat contents
//   in_i     in   mode, char_code, entry_sel, char_pos, entry_len
//   out_o    out  matched, match_entry, delete_count, window_fill
//
// Every command beat yields exactly one result beat; the block takes no new
// command until that result has been taken.
// A command that is not a printable keystroke goes straight to its result.
// A printable keystroke then checks entry after entry: for each it reads the
// length, the boundary character when the window holds more than the
// abbreviation, and one compared character at a time; the single read port of
// the window memory sets that pace.
// Reset empties the window and disables every table entry.
// ----------------------------------------------------------------------------
module hotstring_suffix_matcher
  import hsm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 128,
  parameter int NUM_ENTRIES  = 16,
  parameter int MAX_ABBREV   = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsm_in_if.sink    in_i,
  hsm_out_if.source out_o
);

  localparam int AW   = $clog2(WINDOW_DEPTH);
  localparam int CW   = $clog2(WINDOW_DEPTH + 1);
  localparam int EW   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int IW   = (MAX_ABBREV > 1) ? $clog2(MAX_ABBREV) : 1;
  localparam int LW   = $clog2(MAX_ABBREV + 1);
  localparam int CmpW = (CW > LW) ? CW : LW;

  localparam logic [AW:0]   DepthW   = (AW + 1)'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(WINDOW_DEPTH);
  localparam logic [EW-1:0] LastEnt  = EW'(NUM_ENTRIES - 1);

  state_e           state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [EW-1:0]    entry_q, entry_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [LW-1:0]    len_q, len_d;
  logic             res_match_q, res_match_d;
  logic [EW-1:0]    res_entry_q, res_entry_d;
  logic [LW-1:0]    res_len_q, res_len_d;

  logic [CharW-1:0] win_mem [WINDOW_DEPTH];
  logic [CharW-1:0] win_rdata_q;
  logic             win_we;

  logic             tbl_char_we;
  logic             tbl_len_we;
  logic [CharW-1:0] tbl_char;
  logic [LW-1:0]    tbl_len;
  logic [LW-1:0]    load_len;
  logic             sel_ok;
  logic             pos_ok;

  logic             printable;
  logic             skip_len;
  logic             has_prefix;
  logic             last_entry;
  logic             bnd_word;
  logic             mismatch;
  logic             last_char;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == LastSlot) ? '0 : p + AW'(1);
    return r;
  endfunction

  function automatic logic [AW-1:0] ptr_sub(input logic [AW-1:0] p, input logic [AW:0] x);
    logic [AW:0] t;
    t = {1'b0, p} + DepthW - x;
    if (t >= DepthW) begin
      t = t - DepthW;
    end
    return t[AW-1:0];
  endfunction

  assign printable  = (in_i.char_code >= CharSpace);
  assign sel_ok     = (32'(in_i.entry_sel) < NUM_ENTRIES);
  assign pos_ok     = (32'(in_i.char_pos) < MAX_ABBREV);
  assign load_len   = (32'(in_i.entry_len) > MAX_ABBREV) ? LW'(MAX_ABBREV)
                                                         : LW'(in_i.entry_len);

  assign skip_len   = (tbl_len == '0) || (CmpW'(tbl_len) > CmpW'(count_q));
  assign has_prefix = (CmpW'(count_q) > CmpW'(tbl_len));
  assign last_entry = (entry_q == LastEnt);
  assign bnd_word   = is_word_char(win_rdata_q);
  assign mismatch   = (win_rdata_q != tbl_char);
  assign last_char  = ((LW'(idx_q) + LW'(1)) == len_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = (in_i.mode == MODE_TYPE && printable) ? ST_LEN : ST_DONE;
        end
      end
      ST_LEN: begin
        if (skip_len) begin
          state_d = last_entry ? ST_DONE : ST_LEN;
        end else if (has_prefix) begin
          state_d = ST_BND;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_BND: begin
        if (bnd_word) begin
          state_d = last_entry ? ST_DONE : ST_LEN;
        end else begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (mismatch) begin
          state_d = last_entry ? ST_DONE : ST_LEN;
        end else if (last_char) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    entry_d     = entry_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    len_d       = len_q;
    res_match_d = res_match_q;
    res_entry_d = res_entry_q;
    res_len_d   = res_len_q;
    win_we      = 1'b0;
    tbl_char_we = 1'b0;
    tbl_len_we  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          res_match_d = 1'b0;
          res_entry_d = '0;
          res_len_d   = LW'(1);
          entry_d     = '0;
          unique case (in_i.mode)
            MODE_TYPE: begin
              if (!printable) begin
                head_d  = '0;
                count_d = '0;
              end else begin
                win_we = 1'b1;
                head_d = ptr_inc(head_q);
                if (count_q < FullCnt) begin
                  count_d = count_q + CW'(1);
                end
              end
            end
            MODE_BKSP: begin
              if (count_q != '0) begin
                count_d = count_q - CW'(1);
                head_d  = ptr_sub(head_q, (AW + 1)'(1));
              end
            end
            MODE_BREAK: begin
              head_d  = '0;
              count_d = '0;
            end
            MODE_LOAD_CHAR: begin
              tbl_char_we = sel_ok && pos_ok;
            end
            MODE_LOAD_LEN: begin
              tbl_len_we = sel_ok;
              head_d     = '0;
              count_d    = '0;
            end
            default: ;
          endcase
        end
      end
      ST_LEN: begin
        len_d = tbl_len;
        idx_d = '0;
        if (skip_len) begin
          if (!last_entry) begin
            entry_d = entry_q + EW'(1);
          end
        end else if (has_prefix) begin
          ptr_d = ptr_sub(head_q, (AW + 1)'(tbl_len) + (AW + 1)'(1));
        end else begin
          ptr_d = ptr_sub(head_q, (AW + 1)'(tbl_len));
        end
      end
      ST_BND: begin
        if (bnd_word) begin
          if (!last_entry) begin
            entry_d = entry_q + EW'(1);
          end
        end else begin
          ptr_d = ptr_inc(ptr_q);
        end
      end
      ST_CMP: begin
        if (mismatch) begin
          if (!last_entry) begin
            entry_d = entry_q + EW'(1);
          end
        end else if (last_char) begin
          res_match_d = 1'b1;
          res_entry_d = entry_q;
          res_len_d   = len_q;
          count_d     = count_q - CW'(len_q);
          head_d      = ptr_sub(head_q, (AW + 1)'(len_q));
        end else begin
          ptr_d = ptr_inc(ptr_q);
          idx_d = idx_q + IW'(1);
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      entry_q <= '0;
      ptr_q   <= '0;
      idx_q   <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      entry_q <= entry_d;
      ptr_q   <= ptr_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_match_q <= res_match_d;
    res_entry_q <= res_entry_d;
    res_len_q   <= res_len_d;
  end

  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[head_q] <= in_i.char_code;
    end
    win_rdata_q <= win_mem[ptr_d];
  end

  hsm_abbrev_store #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .MAX_ABBREV  (MAX_ABBREV)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_we_i  (tbl_char_we),
    .len_we_i   (tbl_len_we),
    .wr_entry_i (EW'(in_i.entry_sel)),
    .wr_pos_i   (IW'(in_i.char_pos)),
    .wr_char_i  (in_i.char_code),
    .wr_len_i   (load_len),
    .rd_entry_i (entry_d),
    .rd_pos_i   (idx_d),
    .rd_char_o  (tbl_char),
    .rd_len_o   (tbl_len)
  );

  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = (state_q == ST_DONE);
  assign out_o.matched      = res_match_q;
  assign out_o.match_entry  = res_match_q ? EntryOutW'(res_entry_q) : '0;
  assign out_o.delete_count = res_match_q ? DelW'(res_len_q - LW'(1)) : '0;
  assign out_o.window_fill  = FillW'(count_q);

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hotstring suffix matcher testbench
// Drives command beats from a queue through a valid/ready driver and checks
// every result beat against a cycle-free model of the window and the
// abbreviation table kept here. A short directed sequence covers the special
// cases. Random traffic follows, mostly typed abbreviations with random
// boundaries and content, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb
  import hsm_pkg::*;
;

  localparam int WinDepth    = 128;
  localparam int NumEntries  = 16;
  localparam int MaxAbbrev   = 16;
  localparam int RandomItems = 1700;
  localparam int DrainCycles = 2 + NumEntries * (MaxAbbrev + 2) + 30;
  localparam int MaxIdle     = 12;

  localparam logic [ModeW-1:0] ModeUnusedFirst = 3'd5;
  localparam logic [ModeW-1:0] ModeUnusedLast  = 3'd7;

  localparam logic [CharW-1:0] CharDigitZero = 16'h0030;
  localparam logic [CharW-1:0] CharLowerA    = 16'h0061;
  localparam logic [CharW-1:0] CharLowerB    = 16'h0062;
  localparam logic [CharW-1:0] CharLowerT    = 16'h0074;
  localparam logic [CharW-1:0] CharLowerW    = 16'h0077;
  localparam logic [CharW-1:0] CharBang      = 16'h0021;
  localparam logic [CharW-1:0] CharSlash     = 16'h002F;
  localparam logic [CharW-1:0] CharPeriod    = 16'h002E;
  localparam logic [CharW-1:0] CharTilde     = 16'h007E;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [CharW-1:0]  char_code;
    logic [SelW-1:0]   entry_sel;
    logic [PosW-1:0]   char_pos;
    logic [LenInW-1:0] entry_len;
  } cmd_t;

  typedef struct packed {
    logic                 matched;
    logic [EntryOutW-1:0] match_entry;
    logic [DelW-1:0]      delete_count;
    logic [FillW-1:0]     window_fill;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hsm_in_if  cmd_if ();
  hsm_out_if res_if ();

  hotstring_suffix_matcher #(
    .WINDOW_DEPTH(WinDepth),
    .NUM_ENTRIES (NumEntries),
    .MAX_ABBREV  (MaxAbbrev)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Model of the window and the abbreviation table.
  logic [CharW-1:0] typed_window [WinDepth];
  int               typed_head  = 0;
  int               typed_count = 0;
  logic [CharW-1:0] abbrev_chars [NumEntries][MaxAbbrev];
  int               abbrev_lens  [NumEntries];

  // What the stimulus has loaded so far, so that no enabled entry holds an
  // unwritten character.
  logic [CharW-1:0] loaded_chars [NumEntries][MaxAbbrev];
  bit               char_loaded  [NumEntries][MaxAbbrev];
  int               loaded_lens  [NumEntries];

  cmd_t key_cmds [$];
  res_t pending_match_reports [$];
  cmd_t cur_cmd;
  int   counted_cmds  = 0;
  int   total_cmds    = 0;
  int   accepted_cmds = 0;
  int   mismatches    = 0;

  bit cmd_taken    = 1'b0;
  bit res_taken    = 1'b0;
  bit cmd_idle_on  = 1'b1;
  bit res_idle_on  = 1'b1;
  int cmd_gap      = 0;
  int res_stall    = 0;

  function automatic bit is_ident_char(input logic [CharW-1:0] c);
    return (c inside {[16'h0030:16'h0039], [16'h0041:16'h005A], [16'h0061:16'h007A]}) ||
           (c == CharUnderscore);
  endfunction

  function automatic logic [CharW-1:0] window_char(input int p);
    return typed_window[(typed_head + WinDepth - typed_count + p) % WinDepth];
  endfunction

  task automatic match_step(input cmd_t c, output res_t r);
    int  e;
    int  i;
    int  ln;
    int  off;
    bit  same;
    bit  found;
    r = '0;
    found = 1'b0;
    case (c.mode)
      MODE_TYPE: begin
        if (c.char_code < CharSpace) begin
          typed_head  = 0;
          typed_count = 0;
        end else begin
          if (typed_count < WinDepth) typed_count++;
          typed_window[typed_head] = c.char_code;
          typed_head = (typed_head + 1) % WinDepth;
          for (e = 0; e < NumEntries; e++) begin
            ln = abbrev_lens[e];
            if (!found && ln != 0 && ln <= typed_count) begin
              off = typed_count - ln;
              if (off == 0 || !is_ident_char(window_char(off - 1))) begin
                same = 1'b1;
                for (i = 0; i < ln; i++) begin
                  if (window_char(off + i) != abbrev_chars[e][i]) same = 1'b0;
                end
                if (same) begin
                  found          = 1'b1;
                  r.matched      = 1'b1;
                  r.match_entry  = EntryOutW'(e);
                  r.delete_count = DelW'(ln - 1);
                  typed_count    = off;
                  typed_head     = (typed_head + WinDepth - ln) % WinDepth;
                end
              end
            end
          end
        end
      end
      MODE_BKSP: begin
        if (typed_count > 0) begin
          typed_count--;
          typed_head = (typed_head + WinDepth - 1) % WinDepth;
        end
      end
      MODE_BREAK: begin
        typed_head  = 0;
        typed_count = 0;
      end
      MODE_LOAD_CHAR: begin
        abbrev_chars[c.entry_sel][c.char_pos] = c.char_code;
      end
      MODE_LOAD_LEN: begin
        abbrev_lens[c.entry_sel] = (int'(c.entry_len) > MaxAbbrev) ? MaxAbbrev
                                                                  : int'(c.entry_len);
        typed_head  = 0;
        typed_count = 0;
      end
      default: begin
      end
    endcase
    r.window_fill = FillW'(typed_count);
  endtask

  task automatic push_cmd(input logic [ModeW-1:0] m, input logic [CharW-1:0] ch,
                          input logic [SelW-1:0] sel, input logic [PosW-1:0] pos,
                          input logic [LenInW-1:0] ln);
    cmd_t c;
    c.mode      = m;
    c.char_code = ch;
    c.entry_sel = sel;
    c.char_pos  = pos;
    c.entry_len = ln;
    key_cmds = {key_cmds, c};
    if (m <= MODE_LOAD_LEN) counted_cmds++;
  endtask

  task automatic type_key(input logic [CharW-1:0] ch);
    push_cmd(MODE_TYPE, ch, SelW'($urandom), PosW'($urandom), LenInW'($urandom));
  endtask

  task automatic backspace();
    push_cmd(MODE_BKSP, CharW'($urandom), SelW'($urandom), PosW'($urandom),
             LenInW'($urandom));
  endtask

  task automatic context_break();
    push_cmd(MODE_BREAK, CharW'($urandom), SelW'($urandom), PosW'($urandom),
             LenInW'($urandom));
  endtask

  task automatic load_abbrev_char(input int e, input int p, input logic [CharW-1:0] ch);
    loaded_chars[e][p] = ch;
    char_loaded[e][p]  = 1'b1;
    push_cmd(MODE_LOAD_CHAR, ch, SelW'(e), PosW'(p), LenInW'($urandom));
  endtask

  task automatic load_entry_len(input int e, input int ln);
    loaded_lens[e] = (ln > MaxAbbrev) ? MaxAbbrev : ln;
    push_cmd(MODE_LOAD_LEN, CharW'($urandom), SelW'(e), PosW'($urandom), LenInW'(ln));
  endtask

  function automatic logic [CharW-1:0] abbrev_char_pick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CharW'(CharLowerA + $urandom_range(0, 3));
    if (r < 75) return CharW'(CharDigitZero + $urandom_range(0, 2));
    if (r < 85) return CharUnderscore;
    if (r < 95) return CharW'($urandom_range(CharBang, CharSlash));
    return CharW'($urandom_range(16'h0080, 16'hFFFF));
  endfunction

  function automatic logic [CharW-1:0] separator_pick();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return CharSpace;
    if (r < 9) return CharW'($urandom_range(CharBang, CharSlash));
    return CharW'($urandom_range(16'h00A0, 16'hFFFF));
  endfunction

  function automatic logic [CharW-1:0] noise_pick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CharW'(CharLowerA + $urandom_range(0, 3));
    if (r < 85) return CharW'($urandom_range(CharSpace, CharTilde));
    if (r < 95) return CharW'($urandom_range(0, 16'hFFFF));
    return CharW'($urandom_range(0, CharSpace - 16'd1));
  endfunction

  task automatic program_entry(input int e, input int ln);
    int eff;
    int p;
    eff = (ln > MaxAbbrev) ? MaxAbbrev : ln;
    for (p = 0; p < eff; p++) begin
      if (!char_loaded[e][p] || $urandom_range(0, 3) != 0) load_abbrev_char(e, p, abbrev_char_pick());
    end
    if (eff < MaxAbbrev && $urandom_range(0, 3) == 0) begin
      load_abbrev_char(e, $urandom_range(eff, MaxAbbrev - 1),
                       CharW'($urandom_range(0, 16'hFFFF)));
    end
    load_entry_len(e, ln);
  endtask

  task automatic type_abbrev(input int e, input bit mutate);
    int i;
    int bad;
    logic [CharW-1:0] ch;
    bad = mutate ? int'($urandom_range(0, loaded_lens[e] - 1)) : -1;
    for (i = 0; i < loaded_lens[e]; i++) begin
      ch = loaded_chars[e][i];
      if (i == bad) ch = ch ^ 16'h0001;
      type_key(ch);
    end
  endtask

  function automatic int random_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 70) return $urandom_range(1, 4);
    if (r < 88) return $urandom_range(5, 10);
    if (r < 96) return $urandom_range(11, MaxAbbrev);
    return $urandom_range(MaxAbbrev + 1, 31);
  endfunction

  function automatic int idle_cycles(input bit on);
    return on ? $urandom_range(0, MaxIdle) : 0;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Command driver.
  always @(posedge clk_i) begin
    res_t r;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      match_step(cur_cmd, r);
      pending_match_reports = {pending_match_reports, r};
      accepted_cmds++;
      cmd_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    logic nv;
    if (rst_ni) begin
      nv = cmd_if.valid;
      if (cmd_taken) begin
        cmd_taken = 1'b0;
        nv = 1'b0;
        if ($urandom_range(0, 49) == 0) cmd_idle_on = !cmd_idle_on;
        cmd_gap = idle_cycles(cmd_idle_on);
      end
      if (!nv) begin
        if (cmd_gap > 0) begin
          cmd_gap--;
        end else if (key_cmds.size() > 0) begin
          cur_cmd = key_cmds.pop_front();
          nv = 1'b1;
          cmd_if.mode      <= cur_cmd.mode;
          cmd_if.char_code <= cur_cmd.char_code;
          cmd_if.entry_sel <= cur_cmd.entry_sel;
          cmd_if.char_pos  <= cur_cmd.char_pos;
          cmd_if.entry_len <= cur_cmd.entry_len;
        end
      end
      cmd_if.valid <= nv;
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_match_reports.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, expected none, actual %0d/%0d/%0d/%0d",
                 $time, res_if.matched, res_if.match_entry, res_if.delete_count,
                 res_if.window_fill);
      end else begin
        want = pending_match_reports.pop_front();
        check_field("matched", int'(want.matched), int'(res_if.matched));
        check_field("match_entry", int'(want.match_entry), int'(res_if.match_entry));
        check_field("delete_count", int'(want.delete_count), int'(res_if.delete_count));
        check_field("window_fill", int'(want.window_fill), int'(res_if.window_fill));
      end
      res_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) begin
        res_taken = 1'b0;
        if ($urandom_range(0, 49) == 0) res_idle_on = !res_idle_on;
        res_stall = idle_cycles(res_idle_on);
      end
      if (res_stall > 0) begin
        res_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #(50_000_000);
    $display("FAIL hotstring_suffix_matcher");
    $finish;
  end

  initial begin
    int directed_cmds;
    int act;
    int e;
    int k;
    int n;
    int enabled [$];
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.mode      = MODE_TYPE;
    cmd_if.char_code = '0;
    cmd_if.entry_sel = '0;
    cmd_if.char_pos  = '0;
    cmd_if.entry_len = '0;
    res_if.ready     = 1'b0;
    for (e = 0; e < NumEntries; e++) begin
      abbrev_lens[e] = 0;
      loaded_lens[e] = 0;
      for (k = 0; k < MaxAbbrev; k++) char_loaded[e][k] = 1'b0;
    end

    // Directed: empty table, backspace on an empty window, extreme and
    // control characters, an unused mode, a word boundary that blocks the
    // match, a match at the window start and after a separator, and a
    // disabled entry.
    type_key(CharLowerA);
    backspace();
    backspace();
    type_key(16'hFFFF);
    type_key(CharSpace);
    type_key(16'h0000);
    push_cmd(ModeUnusedFirst, 16'hFFFF, 4'hF, 4'hF, 5'h1F);
    load_abbrev_char(15, 0, CharLowerB);
    load_abbrev_char(15, 1, CharLowerT);
    load_abbrev_char(15, 2, CharLowerW);
    load_entry_len(15, 3);
    type_key(CharLowerT);
    type_key(CharLowerW);
    type_abbrev(15, 1'b0);
    context_break();
    type_abbrev(15, 1'b0);
    type_key(CharPeriod);
    type_abbrev(15, 1'b0);
    load_entry_len(15, 0);
    type_key(CharLowerB);
    directed_cmds = counted_cmds;

    // Random traffic, mostly separator plus abbreviation sequences.
    program_entry(0, $urandom_range(MaxAbbrev + 1, 31));
    for (k = 0; k < 5; k++) program_entry($urandom_range(0, NumEntries - 1),
                                          $urandom_range(1, 6));
    while (counted_cmds - directed_cmds < RandomItems) begin
      act = $urandom_range(0, 99);
      enabled.delete();
      for (e = 0; e < NumEntries; e++) if (loaded_lens[e] > 0) enabled = {enabled, e};
      if (act < 8 || enabled.size() == 0) begin
        program_entry($urandom_range(0, NumEntries - 1), random_length());
      end else if (act < 55) begin
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) type_key(noise_pick());
        k = $urandom_range(0, 19);
        if (k < 16) type_key(separator_pick());
        else if (k < 19) type_key(CharW'(CharLowerA + $urandom_range(0, 3)));
        type_abbrev(enabled[$urandom_range(0, enabled.size() - 1)],
                    $urandom_range(0, 6) == 0);
        if ($urandom_range(0, 3) == 0) backspace();
      end else if (act < 72) begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) type_key(noise_pick());
      end else if (act < 82) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) backspace();
      end else if (act < 87) begin
        context_break();
      end else if (act < 92) begin
        push_cmd(ModeW'($urandom_range(ModeUnusedFirst, ModeUnusedLast)), CharW'($urandom),
                 SelW'($urandom), PosW'($urandom), LenInW'($urandom));
      end else if (act < 93) begin
        n = $urandom_range(WinDepth, WinDepth + 12);
        for (k = 0; k < n; k++) type_key(CharW'($urandom_range(CharSpace, CharTilde)));
        if ($urandom_range(0, 1) == 0) begin
          type_key(separator_pick());
          type_abbrev(enabled[$urandom_range(0, enabled.size() - 1)], 1'b0);
        end
      end else begin
        type_key(CharW'($urandom_range(0, CharSpace - 16'd1)));
        type_abbrev(enabled[$urandom_range(0, enabled.size() - 1)], 1'b0);
      end
    end
    total_cmds = key_cmds.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cmds < total_cmds || pending_match_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS hotstring_suffix_matcher");
    end else begin
      $display("FAIL hotstring_suffix_matcher");
    end
    $finish;
  end

endmodule

### hotstring_suffix_matcher.f
rtl/core/hsm_pkg.sv
rtl/core/hsm_in_if.sv
rtl/core/hsm_out_if.sv
rtl/core/hsm_abbrev_store.sv
rtl/core/hotstring_suffix_matcher.sv
tb/tb.sv
